@@ hw/rtl/scts_pkg.sv @@
// Shared types, constants and helpers of the sprite column texture sampler.
// Used by the front end, the back end, the top level and the testbench; depends on nothing.
package scts_pkg;

  // Action codes of an input item.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DRAW = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_WIN_X_START = 3'd0;
  localparam logic [2:0] CFG_WIN_X_END   = 3'd1;
  localparam logic [2:0] CFG_WIN_Y_START = 3'd2;
  localparam logic [2:0] CFG_WIN_Y_END   = 3'd3;
  localparam logic [2:0] CFG_SPR_WIDTH   = 3'd4;
  localparam logic [2:0] CFG_SPR_HEIGHT  = 3'd5;
  localparam logic [2:0] CFG_SPR_CENTER  = 3'd6;
  localparam logic [2:0] CFG_VERT_SHIFT  = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Low 24 bits of a texel decide whether it is drawn.
  localparam logic [31:0] COLOR_MASK = 32'h00FF_FFFF;

  typedef struct packed {
    logic               action;
    logic [9:0]         pixel_x;
    logic [9:0]         pixel_y;
    logic signed [31:0] column_depth;
    logic signed [31:0] sprite_depth;
    logic [1:0]         texture_select;
    logic [11:0]        texel_index;
    logic [31:0]        texel_value;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  write_x;
    logic [9:0]  write_y;
    logic [31:0] write_color;
  } out_item_t;

  typedef struct packed {
    logic [10:0]        win_x_start;
    logic [10:0]        win_x_end;
    logic [10:0]        win_y_start;
    logic [10:0]        win_y_end;
    logic [15:0]        spr_width;
    logic [15:0]        spr_height;
    logic signed [15:0] spr_center;
    logic signed [15:0] vert_shift;
  } cfg_t;

  // Fields that ride along with an item through the back end.
  typedef struct packed {
    logic        draw_ok;
    logic        load_ok;
    logic [9:0]  px;
    logic [9:0]  py;
    logic [1:0]  sel;
    logic [11:0] tidx;
    logic [31:0] tval;
  } carry_t;

  // Classified item between front and back end.
  typedef struct packed {
    carry_t             c;
    logic signed [17:0] p_x;
    logic signed [25:0] d_y;
  } mid_item_t;

  // A divisor of zero behaves as one.
  function automatic logic [15:0] eff_div(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

@@ hw/rtl/scts_fifo.sv @@
// Small synchronous first-in first-out queue built from registers.
// Generic; used between front and back end and on the result side.
module scts_fifo #(
  parameter int W  = 8,
  parameter int AW = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [W-1:0]  wdata,
  input  logic          pop,
  output logic [W-1:0]  rdata,
  output logic          full,
  output logic          empty,
  output logic [AW:0]   count
);

  localparam int DEPTH = 2 ** AW;

  logic [W-1:0] mem [DEPTH];
  logic [AW:0]  wptr_r, wptr_nxt;
  logic [AW:0]  rptr_r, rptr_nxt;

  assign count = wptr_r - rptr_r;
  assign empty = (wptr_r == rptr_r);
  assign full  = (wptr_r[AW] != rptr_r[AW]) && (wptr_r[AW-1:0] == rptr_r[AW-1:0]);
  assign rdata = mem[rptr_r[AW-1:0]];

  // Pointer update on each transfer.
  always_comb begin
    wptr_nxt = wptr_r + ((push && !full) ? (AW+1)'(1) : (AW+1)'(0));
    rptr_nxt = rptr_r + ((pop && !empty) ? (AW+1)'(1) : (AW+1)'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr_r[AW-1:0]] <= wdata;
    end
  end

endmodule

@@ hw/rtl/scts_front.sv @@
// Front end: checks window, depth and texture range of an item and forms
// the signed coordinate numerators. Depends on scts_pkg.
module scts_front #(
  parameter int TEXTURE_SIZE  = 64,
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480,
  parameter int TEXTURE_COUNT = 4
) (
  input  scts_pkg::in_item_t  item,
  input  scts_pkg::cfg_t      cfg,
  output scts_pkg::mid_item_t mid
);
  import scts_pkg::*;

  localparam int TPT = TEXTURE_SIZE * TEXTURE_SIZE;

  logic [15:0]        weff;
  logic [15:0]        heff;
  logic               in_win;
  logic               depth_ok;
  logic               sel_ok;
  logic signed [25:0] row_off;

  // Classification of the item.
  always_comb begin
    weff     = eff_div(cfg.spr_width);
    heff     = eff_div(cfg.spr_height);
    in_win   = ({1'b0, item.pixel_x} >= cfg.win_x_start) &&
               ({1'b0, item.pixel_x} <  cfg.win_x_end) &&
               ({1'b0, item.pixel_y} >= cfg.win_y_start) &&
               ({1'b0, item.pixel_y} <  cfg.win_y_end);
    depth_ok = (item.sprite_depth > 32'sd0) &&
               (item.sprite_depth < item.column_depth) &&
               (item.pixel_x != 10'd0) &&
               ({1'b0, item.pixel_x} < 11'(SCREEN_WIDTH));
    sel_ok   = ({3'd0, item.texture_select} < 5'(TEXTURE_COUNT));

    mid.c.draw_ok = (item.action == ACT_DRAW) && in_win && depth_ok && sel_ok;
    mid.c.load_ok = (item.action == ACT_LOAD) && sel_ok &&
                    ({5'd0, item.texel_index} < 17'(TPT));
    mid.c.px      = item.pixel_x;
    mid.c.py      = item.pixel_y;
    mid.c.sel     = item.texture_select;
    mid.c.tidx    = item.texel_index;
    mid.c.tval    = item.texel_value;

    // Horizontal offset from the left sprite edge.
    mid.p_x = $signed({8'd0, item.pixel_x}) - 18'(cfg.spr_center) +
              $signed({3'd0, weff[15:1]});

    // Vertical numerator in 1/256 pixel steps.
    row_off = $signed({16'd0, item.pixel_y}) - 26'(cfg.vert_shift);
    mid.d_y = (row_off <<< 8) - 26'(SCREEN_HEIGHT * 128) +
              $signed({3'd0, heff, 7'd0});
  end

endmodule

@@ hw/rtl/scts_back.sv @@
// Back end: pipelined restoring dividers for both texture coordinates,
// address forming and the texture store. Depends on scts_pkg.
module scts_back #(
  parameter int TEXTURE_SIZE  = 64,
  parameter int TEXTURE_COUNT = 4,
  parameter int OQ_AW         = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  scts_pkg::cfg_t      cfg,
  input  scts_pkg::mid_item_t mid,
  input  logic                mid_empty,
  output logic                mid_pop,
  input  logic [OQ_AW:0]      out_cnt,
  output logic                res_push,
  output scts_pkg::out_item_t res_item
);
  import scts_pkg::*;

  localparam int QW     = $clog2(TEXTURE_SIZE);
  localparam int RW     = 25 + $clog2(TEXTURE_SIZE + 1);
  localparam int TPT    = TEXTURE_SIZE * TEXTURE_SIZE;
  localparam int DEPTH  = TEXTURE_COUNT * TPT;
  localparam int AW     = $clog2(DEPTH);
  localparam int LAT    = QW + 4;
  localparam int IW     = $clog2(LAT + 1);
  localparam int OQ_DEP = 2 ** OQ_AW;

  logic [RW-1:0] dx;
  logic [RW-1:0] dy;
  logic [IW-1:0] infl_r, infl_nxt;

  // Divisors: width, and height in 1/256 steps.
  assign dx = RW'(eff_div(cfg.spr_width));
  assign dy = RW'({eff_div(cfg.spr_height), 8'd0});

  // Issue only with a guaranteed place in the result queue.
  assign mid_pop = !mid_empty &&
                   ((32'(infl_r) + 32'(out_cnt)) < 32'(OQ_DEP));

  // Stage A: magnitudes scaled by the texture size.
  logic          a_v_r;
  carry_t        a_c_r;
  logic [RW-1:0] a_ax_r, a_ay_r;
  logic [17:0]   abs_x;
  logic [25:0]   abs_y;

  always_comb begin
    abs_x = (mid.p_x < 0) ? 18'(-mid.p_x) : 18'(mid.p_x);
    abs_y = (mid.d_y < 0) ? 26'(-mid.d_y) : 26'(mid.d_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= mid_pop;
    end
  end

  always_ff @(posedge clk) begin
    a_c_r  <= mid.c;
    a_ax_r <= RW'(abs_x) * RW'(TEXTURE_SIZE);
    a_ay_r <= RW'(abs_y) * RW'(TEXTURE_SIZE);
  end

  // Stage S: saturation when the quotient reaches the texture size.
  logic          s_v_r;
  carry_t        s_c_r;
  logic [RW-1:0] s_rx_r, s_ry_r;
  logic          s_sx_r, s_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else begin
      s_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s_c_r  <= a_c_r;
    s_rx_r <= a_ax_r;
    s_ry_r <= a_ay_r;
    s_sx_r <= (a_ax_r >= RW'(dx * RW'(TEXTURE_SIZE)));
    s_sy_r <= (a_ay_r >= RW'(dy * RW'(TEXTURE_SIZE)));
  end

  // Divider stages, one quotient bit per stage, most significant first.
  logic [QW-1:0] dv_v_r;
  carry_t        dv_c_r  [QW];
  logic [RW-1:0] dv_rx_r [QW];
  logic [RW-1:0] dv_ry_r [QW];
  logic [QW-1:0] dv_qx_r [QW];
  logic [QW-1:0] dv_qy_r [QW];
  logic [QW-1:0] dv_sx_r;
  logic [QW-1:0] dv_sy_r;

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int BIT = QW - 1 - k;
    logic          v_in, sx_in, sy_in;
    carry_t        c_in;
    logic [RW-1:0] rx_in, ry_in, dxs, dys;
    logic [QW-1:0] qx_in, qy_in;

    if (k == 0) begin : g_first
      assign v_in  = s_v_r;
      assign c_in  = s_c_r;
      assign rx_in = s_rx_r;
      assign ry_in = s_ry_r;
      assign qx_in = '0;
      assign qy_in = '0;
      assign sx_in = s_sx_r;
      assign sy_in = s_sy_r;
    end else begin : g_next
      assign v_in  = dv_v_r[k-1];
      assign c_in  = dv_c_r[k-1];
      assign rx_in = dv_rx_r[k-1];
      assign ry_in = dv_ry_r[k-1];
      assign qx_in = dv_qx_r[k-1];
      assign qy_in = dv_qy_r[k-1];
      assign sx_in = dv_sx_r[k-1];
      assign sy_in = dv_sy_r[k-1];
    end

    assign dxs = dx << BIT;
    assign dys = dy << BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else begin
        dv_v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      dv_c_r[k]  <= c_in;
      dv_sx_r[k] <= sx_in;
      dv_sy_r[k] <= sy_in;
      dv_rx_r[k] <= (rx_in >= dxs) ? rx_in - dxs : rx_in;
      dv_ry_r[k] <= (ry_in >= dys) ? ry_in - dys : ry_in;
      dv_qx_r[k] <= qx_in | ((rx_in >= dxs) ? QW'(1) << BIT : QW'(0));
      dv_qy_r[k] <= qy_in | ((ry_in >= dys) ? QW'(1) << BIT : QW'(0));
    end
  end

  // Stage R: clamp and form the store address.
  logic          r_v_r;
  carry_t        r_c_r;
  logic [AW-1:0] r_addr_r;
  logic [QW-1:0] tx, ty;
  logic [31:0]   draw_addr, load_addr;
  carry_t        dl_c;

  always_comb begin
    dl_c      = dv_c_r[QW-1];
    tx        = dv_sx_r[QW-1] ? QW'(TEXTURE_SIZE - 1) : dv_qx_r[QW-1];
    ty        = dv_sy_r[QW-1] ? QW'(TEXTURE_SIZE - 1) : dv_qy_r[QW-1];
    draw_addr = 32'(dl_c.sel) * 32'(TPT) + 32'(ty) * 32'(TEXTURE_SIZE) + 32'(tx);
    load_addr = 32'(dl_c.sel) * 32'(TPT) + 32'(dl_c.tidx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
    end else begin
      r_v_r <= dv_v_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    r_c_r    <= dl_c;
    r_addr_r <= dl_c.load_ok ? load_addr[AW-1:0] : draw_addr[AW-1:0];
  end

  // Stage M: texture store, loads write and draws read in item order.
  logic [31:0] tex_mem [DEPTH];
  logic        m_v_r;
  carry_t      m_c_r;
  logic [31:0] m_rdata_r;

  always_ff @(posedge clk) begin
    if (r_v_r && r_c_r.load_ok) begin
      tex_mem[r_addr_r] <= r_c_r.tval;
    end
    m_rdata_r <= tex_mem[r_addr_r];
    m_c_r     <= r_c_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else begin
      m_v_r <= r_v_r;
    end
  end

  // Result: a drawn pixel whose color is not transparent.
  assign res_push             = m_v_r && m_c_r.draw_ok &&
                                ((m_rdata_r & COLOR_MASK) != 32'd0);
  assign res_item.write_x     = m_c_r.px;
  assign res_item.write_y     = m_c_r.py;
  assign res_item.write_color = m_rdata_r;

  // Count of items inside the pipeline.
  always_comb begin
    infl_nxt = infl_r + (mid_pop ? IW'(1) : IW'(0)) - (m_v_r ? IW'(1) : IW'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      infl_r <= '0;
    end else begin
      infl_r <= infl_nxt;
    end
  end

endmodule

@@ hw/rtl/sprite_column_texture_sampler_top.sv @@
// Sprite column texture sampler: front end, queue, back end, result queue.
// An item passes the back-end stages A, S, the divider stages, R and M
// before it reaches the result queue. Throughput: one item per cycle while
// the result queue has room for all items in flight, set by the
// one-bit-per-stage dividers and the single store port. Reset (rst_n low,
// synchronous) empties both queues, clears the pipeline and loads register
// defaults; the texture store keeps its contents and is undefined until written.
module sprite_column_texture_sampler_top #(
  parameter int TEXTURE_SIZE  = 64,
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480,
  parameter int TEXTURE_COUNT = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  scts_pkg::in_item_t                  in_item,
  output logic                                out_empty,
  input  logic                                out_pop,
  output scts_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [scts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scts_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import scts_pkg::*;

  localparam int QW    = $clog2(TEXTURE_SIZE);
  localparam int OQ_AW = $clog2(QW + 6);
  localparam int MQ_AW = 2;
  localparam int MW    = $bits(mid_item_t);
  localparam int OW    = $bits(out_item_t);

  cfg_t            cfg_r, cfg_nxt;
  mid_item_t       mid_in, mid_out;
  logic [MW-1:0]   mid_rdata;
  logic            mid_full, mid_empty, mid_pop;
  logic [MQ_AW:0]  mid_cnt;
  logic            res_push, out_full;
  out_item_t       res_item;
  logic [OW-1:0]   out_rdata;
  logic [OQ_AW:0]  out_cnt;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIN_X_START: cfg_nxt.win_x_start = cfg_wdata[10:0];
        CFG_WIN_X_END:   cfg_nxt.win_x_end   = cfg_wdata[10:0];
        CFG_WIN_Y_START: cfg_nxt.win_y_start = cfg_wdata[10:0];
        CFG_WIN_Y_END:   cfg_nxt.win_y_end   = cfg_wdata[10:0];
        CFG_SPR_WIDTH:   cfg_nxt.spr_width   = cfg_wdata;
        CFG_SPR_HEIGHT:  cfg_nxt.spr_height  = cfg_wdata;
        CFG_SPR_CENTER:  cfg_nxt.spr_center  = $signed(cfg_wdata);
        CFG_VERT_SHIFT:  cfg_nxt.vert_shift  = $signed(cfg_wdata);
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{11'd0, 11'd0, 11'd0, 11'd0, 16'd1, 16'd1, 16'sd0, 16'sd0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end classifies the incoming item.
  scts_front #(
    .TEXTURE_SIZE (TEXTURE_SIZE),
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .TEXTURE_COUNT(TEXTURE_COUNT)
  ) u_front (
    .item(in_item),
    .cfg (cfg_r),
    .mid (mid_in)
  );

  // Queue between front and back end.
  scts_fifo #(
    .W (MW),
    .AW(MQ_AW)
  ) u_mid_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (in_push),
    .wdata(mid_in),
    .pop  (mid_pop),
    .rdata(mid_rdata),
    .full (mid_full),
    .empty(mid_empty),
    .count(mid_cnt)
  );

  assign in_full = mid_full;
  assign mid_out = mid_item_t'(mid_rdata);

  // Back end computes coordinates and accesses the store.
  scts_back #(
    .TEXTURE_SIZE (TEXTURE_SIZE),
    .TEXTURE_COUNT(TEXTURE_COUNT),
    .OQ_AW        (OQ_AW)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .mid      (mid_out),
    .mid_empty(mid_empty),
    .mid_pop  (mid_pop),
    .out_cnt  (out_cnt),
    .res_push (res_push),
    .res_item (res_item)
  );

  // Result queue.
  scts_fifo #(
    .W (OW),
    .AW(OQ_AW)
  ) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res_item),
    .pop  (out_pop),
    .rdata(out_rdata),
    .full (out_full),
    .empty(out_empty),
    .count(out_cnt)
  );

  assign out_item = out_item_t'(out_rdata);

  // The credit scheme must never overrun the result queue.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !out_full)
    else $error("result pushed into a full queue");

  // A result only appears after the back end delivered one.
  a_fill_source: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> $past(res_push))
    else $error("result queue filled without a push");

  // Issue to the back end only from a non-empty queue, with the result queue count within its depth.
  a_issue_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> !mid_empty && (out_cnt <= (OQ_AW+1)'(2 ** OQ_AW)))
    else $error("back end issued from an empty queue");

  // The queue between front and back end never holds more than its depth.
  a_mid_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mid_cnt <= (MQ_AW+1)'(2 ** MQ_AW))
    else $error("front queue count beyond its depth");

endmodule

@@ verif/tb_sprite_column_texture_sampler_top.sv @@
`timescale 1ns / 1ps
// Testbench for the sprite column texture sampler: directed and random pixels
// checked against an in-bench predictor. Depends on scts_pkg and the top level.
module tb_sprite_column_texture_sampler_top;
  import scts_pkg::*;

  localparam int TEX_EDGE  = 64;
  localparam int TEX_TEXELS = TEX_EDGE * TEX_EDGE;
  localparam int TEX_COUNT = 4;
  localparam int SCR_W = 640;
  localparam int SCR_H = 480;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_item = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  sprite_column_texture_sampler_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the block's settings and texture store.
  int win_xs, win_xe, win_ys, win_ye;
  int spr_w, spr_h, spr_center, vshift;
  logic [31:0] texels [0:TEX_COUNT*TEX_TEXELS-1];
  bit texel_written [0:TEX_COUNT*TEX_TEXELS-1];

  out_item_t pending_writes[$];
  int errors = 0;
  bit no_idle = 1'b0;
  int rx_hold = 0;
  bit rx_enable = 1'b0;

  // Clamp of a texture coordinate after taking its magnitude.
  function automatic longint fold(input longint c);
    if (c < 0) c = -c;
    if (c > TEX_EDGE - 1) c = TEX_EDGE - 1;
    return c;
  endfunction

  // Store address that a draw would sample.
  function automatic int sample_addr(input in_item_t it);
    longint w, h, left, tx, d, ty;
    w = (spr_w == 0) ? 1 : spr_w;
    h = (spr_h == 0) ? 1 : spr_h;
    left = longint'(spr_center) - w / 2;
    tx = ((256 * (longint'(it.pixel_x) - left) * TEX_EDGE) / w) / 256;
    d = (longint'(it.pixel_y) - longint'(vshift)) * 256 - SCR_H * 128 + h * 128;
    ty = ((d * TEX_EDGE) / h) / 256;
    return int'(it.texture_select) * TEX_TEXELS + int'(fold(ty)) * TEX_EDGE
           + int'(fold(tx));
  endfunction

  // Framebuffer write that a draw produces, if any.
  function automatic bit predict_pixel(input in_item_t it, output out_item_t wr);
    logic [31:0] color;
    wr = '0;
    if (it.pixel_x < win_xs || it.pixel_x >= win_xe) return 1'b0;
    if (it.pixel_y < win_ys || it.pixel_y >= win_ye) return 1'b0;
    if (!(it.sprite_depth > 0 && it.pixel_x > 0 && it.pixel_x < SCR_W &&
          it.sprite_depth < it.column_depth)) return 1'b0;
    color = texels[sample_addr(it)];
    if ((color & COLOR_MASK) == 0) return 1'b0;
    wr.write_x = it.pixel_x;
    wr.write_y = it.pixel_y;
    wr.write_color = color;
    return 1'b1;
  endfunction

  // One input transfer; the expectation is recorded when it is accepted.
  task automatic send_raw(input in_item_t it);
    int gap;
    out_item_t wr;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    if (it.action == ACT_LOAD) begin
      texels[int'(it.texture_select) * TEX_TEXELS + it.texel_index] = it.texel_value;
      texel_written[int'(it.texture_select) * TEX_TEXELS + it.texel_index] = 1'b1;
    end else if (predict_pixel(it, wr)) begin
      pending_writes.push_back(wr);
    end
  endtask

  function automatic in_item_t load_item(input int sel, input int idx,
                                         input logic [31:0] val);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.action = ACT_LOAD;
    it.texture_select = sel[1:0];
    it.texel_index = idx[11:0];
    it.texel_value = val;
    return it;
  endfunction

  function automatic in_item_t draw_item(input int px, input int py, input int cd,
                                         input int sd, input int sel);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.action = ACT_DRAW;
    it.pixel_x = px[9:0];
    it.pixel_y = py[9:0];
    it.column_depth = cd;
    it.sprite_depth = sd;
    it.texture_select = sel[1:0];
    return it;
  endfunction

  function automatic logic [31:0] rand_color();
    logic [31:0] c;
    c = $urandom;
    if ($urandom_range(0, 7) == 0) c[23:0] = 24'h0;
    return c;
  endfunction

  // Draws never sample a texel that was never loaded: load it first.
  task automatic send_item(input in_item_t it);
    int addr;
    if (it.action == ACT_DRAW) begin
      addr = sample_addr(it);
      if (!texel_written[addr])
        send_raw(load_item(addr / TEX_TEXELS, addr % TEX_TEXELS, rand_color()));
    end
    send_raw(it);
  endtask

  // One register write; the caller drops the write enable after the last one.
  task automatic write_reg(input logic [2:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[15:0];
    @(posedge clk);
    case (idx)
      CFG_WIN_X_START: win_xs = val & 'h7FF;
      CFG_WIN_X_END:   win_xe = val & 'h7FF;
      CFG_WIN_Y_START: win_ys = val & 'h7FF;
      CFG_WIN_Y_END:   win_ye = val & 'h7FF;
      CFG_SPR_WIDTH:   spr_w = val & 'hFFFF;
      CFG_SPR_HEIGHT:  spr_h = val & 'hFFFF;
      CFG_SPR_CENTER:  spr_center = int'($signed(val[15:0]));
      CFG_VERT_SHIFT:  vshift = int'($signed(val[15:0]));
      default: ;
    endcase
  endtask

  task automatic set_config(input int xs, input int xe, input int ys, input int ye,
                            input int w, input int h, input int c, input int vs);
    write_reg(CFG_WIN_X_START, xs);
    write_reg(CFG_WIN_X_END, xe);
    write_reg(CFG_WIN_Y_START, ys);
    write_reg(CFG_WIN_Y_END, ye);
    write_reg(CFG_SPR_WIDTH, w);
    write_reg(CFG_SPR_HEIGHT, h);
    write_reg(CFG_SPR_CENTER, c);
    write_reg(CFG_VERT_SHIFT, vs);
    cfg_we <= 1'b0;
  endtask

  // Stop offering items, let every expected write arrive and the pipe empty.
  task automatic wait_idle();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed draws inside the window; the rest is noise.
  task automatic random_draws(input int count);
    int px, py, sd;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(load_item($urandom_range(0, 3), $urandom_range(0, 4095), $urandom));
      end else if ($urandom_range(0, 9) == 0) begin
        send_item(draw_item($urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom, $urandom, $urandom_range(0, 3)));
      end else begin
        px = (win_xe > win_xs) ? $urandom_range(win_xs, win_xe - 1) : 0;
        py = (win_ye > win_ys) ? $urandom_range(win_ys, win_ye - 1) : 0;
        sd = $urandom_range(1, 32'h3FFF_FFFF);
        send_item(draw_item(px, py, sd + $urandom_range(1, 32'h3FFF_FFFF), sd,
                            $urandom_range(0, 3)));
      end
    end
  endtask

  task automatic test_directed();
    set_config(0, 1024, 0, 1024, 64, 64, 320, 0);
    for (int s = 0; s < TEX_COUNT; s++)
      send_item(load_item(s, 0, 32'hFFFF_FFFF));
    send_item(load_item(1, 4095, 32'h0000_0001));
    send_item(draw_item(320, 240, 32'h7FFF_FFFF, 1, 0));
    send_item(draw_item(1, 0, 32'h0002_0000, 32'h0001_0000, 1));
    send_item(draw_item(639, 1023, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 2));
    send_item(draw_item(0, 240, 32'h0002_0000, 32'h0001_0000, 3));       // column 0
    send_item(draw_item(640, 240, 32'h0002_0000, 32'h0001_0000, 3));     // past screen
    send_item(draw_item(1023, 240, 32'h0002_0000, 32'h0001_0000, 3));
    send_item(draw_item(300, 240, 32'h0002_0000, 0, 0));                 // depth zero
    send_item(draw_item(300, 240, 32'h0002_0000, 32'h8000_0000, 0));     // negative
    send_item(draw_item(300, 240, 32'h0002_0000, 32'h0002_0000, 0));     // equal depth
    send_item(draw_item(300, 240, 32'h8000_0000, 32'h0001_0000, 0));
    send_item(load_item(2, 100, 32'hFF00_0000));                         // blank color
    send_item(load_item(2, 100, 32'hFF00_0000));
    send_item(draw_item(360, 240, 32'h7FFF_FFFF, 5, 2));
    wait_idle();
    // Zero divisors act as one; narrow window edges.
    set_config(10, 11, 1023, 1024, 0, 0, -32768, 32767);
    send_item(draw_item(10, 1023, 32'h7FFF_FFFF, 1, 1));
    send_item(draw_item(11, 1023, 32'h7FFF_FFFF, 1, 1));
    send_item(draw_item(9, 1023, 32'h7FFF_FFFF, 1, 1));
    send_item(draw_item(10, 1022, 32'h7FFF_FFFF, 1, 1));
    wait_idle();
  endtask

  task automatic test_random();
    no_idle = 1'b0;
    set_config($urandom_range(0, 100), $urandom_range(500, 1024),
               $urandom_range(0, 100), $urandom_range(400, 1024),
               $urandom_range(1, 400), $urandom_range(1, 400),
               $urandom_range(0, 640), $urandom_range(0, 200) - 100);
    random_draws(100);
    wait_idle();
    no_idle = 1'b1;
    set_config(0, 1024, 0, 1024, $urandom_range(16, 128), $urandom_range(16, 128),
               $urandom_range(200, 440), $urandom_range(0, 80) - 40);
    random_draws(80);
    wait_idle();
    no_idle = 1'b0;
    set_config(0, 1024, 0, 1024, 65535, 65535, 32767, -32768);
    random_draws(80);
    wait_idle();
    set_config(1024, 0, 0, 1024, 1, 1, 0, 0);
    random_draws(20);
    wait_idle();
  endtask

  // Receiver holds off while the sender keeps pushing back to back.
  task automatic test_backpressure();
    set_config(0, 1024, 0, 1024, 32, 32, 320, 0);
    no_idle = 1'b1;
    rx_hold = 400;
    random_draws(100);
    no_idle = 1'b0;
    wait_idle();
  endtask

  // Result side: random stalls, each transfer checked against the oldest write.
  initial begin : result_checker
    int stall;
    out_item_t exp_wr;
    wait (rx_enable);
    forever begin
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      if (pending_writes.size() == 0) begin
        $error("unexpected write x=%0d y=%0d color=%h",
               out_item.write_x, out_item.write_y, out_item.write_color);
        errors++;
      end else begin
        exp_wr = pending_writes.pop_front();
        if (out_item.write_x !== exp_wr.write_x) begin
          $error("write_x expected %0d actual %0d", exp_wr.write_x, out_item.write_x);
          errors++;
        end
        if (out_item.write_y !== exp_wr.write_y) begin
          $error("write_y expected %0d actual %0d", exp_wr.write_y, out_item.write_y);
          errors++;
        end
        if (out_item.write_color !== exp_wr.write_color) begin
          $error("write_color expected %h actual %h",
                 exp_wr.write_color, out_item.write_color);
          errors++;
        end
      end
    end
  end

  initial begin : run_limit
    #5ms;
    $display("status: fail");
    $finish;
  end

  initial begin : main
    win_xs = 0; win_xe = 0; win_ys = 0; win_ye = 0;
    spr_w = 1; spr_h = 1; spr_center = 0; vshift = 0;
    foreach (texel_written[i]) texel_written[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    rx_enable = 1'b1;
    test_directed();
    test_random();
    test_backpressure();
    if (pending_writes.size() != 0) begin
      $error("%0d expected writes never arrived", pending_writes.size());
      errors++;
    end
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/scts_pkg.sv
hw/rtl/scts_fifo.sv
hw/rtl/scts_front.sv
hw/rtl/scts_back.sv
hw/rtl/sprite_column_texture_sampler_top.sv
verif/tb_sprite_column_texture_sampler_top.sv
